/* rtl/sss_pkg.sv */
// Shared types and constants for the sample set statistics unit.
// Used by every module of the block; depends on nothing.
package sss_pkg;

  localparam int SampleW    = 16;
  localparam int CountW     = 17;
  localparam int MaxSamples = 65536;
  localparam int SumW       = 32;
  localparam int SqSumW     = 47;
  localparam int SquareW    = 32;
  localparam int MagW       = 32;

  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam int DivW       = 80;
  localparam int DivisorW   = 34;
  localparam int DivCntW    = $clog2(DivW + 1);
  localparam int QuotW      = 48;

  localparam int MeanW      = 24;
  localparam int SdW        = 24;

  localparam logic signed [SampleW-1:0] MinInit = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] MaxInit = {1'b1, {(SampleW-1){1'b0}}};

  localparam logic [QuotW-1:0] MeanPosLimit = QuotW'(8388607);
  localparam logic [QuotW-1:0] MeanNegLimit = QuotW'(8388608);
  localparam logic [MeanW-1:0] MeanPosSat   = 24'h7FFFFF;
  localparam logic [MeanW-1:0] MeanNegSat   = 24'h800000;

  localparam logic [QuotW-1:0] SqrtTopBit   = QuotW'(1) << (QuotW - 2);

  // Totals of one finished set, handed from the front to the back.
  typedef struct packed {
    logic signed [SampleW-1:0] min_value;
    logic signed [SampleW-1:0] max_value;
    logic signed [SumW-1:0]    sum;
    logic [SqSumW-1:0]         sum_sq;
    logic [CountW-1:0]         count;
    logic                      overflow;
  } set_rec_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL0,
    BK_MUL1,
    BK_SUM,
    BK_DIFF,
    BK_MEAN_START,
    BK_MEAN_WAIT,
    BK_VAR_START,
    BK_VAR_WAIT,
    BK_SQRT,
    BK_OUT
  } back_state_e;

endpackage

/* rtl/sss_front.sv */
// Front part: squares each sample, then accumulates min, max, sum, sum of squares and count.
// Pushes one set record per finished set into the set queue. Depends on sss_pkg.
module sss_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sss_pkg::SampleW-1:0]  sample_i,
  input  logic                                last_i,
  input  logic [sss_pkg::FifoCntW-1:0]        fifo_cnt_i,
  output logic                                rec_push_o,
  output sss_pkg::set_rec_t                   rec_o
);

  logic                                accept;
  logic                                s1_valid_q, s1_last_q;
  logic signed [sss_pkg::SampleW-1:0]  s1_sample_q;
  logic [sss_pkg::SquareW-1:0]         s1_square_q;
  logic [sss_pkg::FifoCntW:0]          need;

  logic signed [sss_pkg::SampleW-1:0]  min_q, max_q, min_d, max_d;
  logic signed [sss_pkg::SumW-1:0]     sum_q, sum_d;
  logic [sss_pkg::SqSumW-1:0]          sum_sq_q, sum_sq_d;
  logic [sss_pkg::CountW-1:0]          count_q, count_d;
  logic                                ovf_q, ovf_d;
  logic                                take;

  // A request in stage one that ends a set takes a queue slot at the end of this cycle.
  assign need   = {1'b0, fifo_cnt_i} + (sss_pkg::FifoCntW + 1)'(s1_valid_q & s1_last_q);
  assign full   = need >= (sss_pkg::FifoCntW + 1)'(sss_pkg::FifoDepth);
  assign accept = push & ~full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q   <= last_i;
      s1_sample_q <= sample_i;
      s1_square_q <= sss_pkg::SquareW'(sss_pkg::SquareW'(sample_i) *
                                       sss_pkg::SquareW'(sample_i));
    end
  end

  assign take = s1_valid_q && (count_q < sss_pkg::CountW'(sss_pkg::MaxSamples));

  always_comb begin
    min_d    = (take && (s1_sample_q < min_q)) ? s1_sample_q : min_q;
    max_d    = (take && (s1_sample_q > max_q)) ? s1_sample_q : max_q;
    sum_d    = take ? sum_q + sss_pkg::SumW'(s1_sample_q) : sum_q;
    sum_sq_d = take ? sum_sq_q + sss_pkg::SqSumW'(s1_square_q) : sum_sq_q;
    count_d  = count_q + sss_pkg::CountW'(take);
    ovf_d    = ovf_q | (s1_valid_q & ~take);
  end

  assign rec_push_o       = s1_valid_q & s1_last_q;
  assign rec_o.min_value  = min_d;
  assign rec_o.max_value  = max_d;
  assign rec_o.sum        = sum_d;
  assign rec_o.sum_sq     = sum_sq_d;
  assign rec_o.count      = count_d;
  assign rec_o.overflow   = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= sss_pkg::MinInit;
      max_q    <= sss_pkg::MaxInit;
      sum_q    <= '0;
      sum_sq_q <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (s1_valid_q && s1_last_q) begin
      min_q    <= sss_pkg::MinInit;
      max_q    <= sss_pkg::MaxInit;
      sum_q    <= '0;
      sum_sq_q <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (s1_valid_q) begin
      min_q    <= min_d;
      max_q    <= max_d;
      sum_q    <= sum_d;
      sum_sq_q <= sum_sq_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

/* rtl/sss_fifo.sv */
// Short queue of finished set records between the front and the back.
// Depends on sss_pkg for the record type and depth.
module sss_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  sss_pkg::set_rec_t             rec_i,
  input  logic                          pop_i,
  output sss_pkg::set_rec_t             rec_o,
  output logic                          empty_o,
  output logic [sss_pkg::FifoCntW-1:0]  cnt_o
);

  sss_pkg::set_rec_t               mem_q [sss_pkg::FifoDepth];
  logic [sss_pkg::FifoPtrW-1:0]    wptr_q, rptr_q;
  logic [sss_pkg::FifoCntW-1:0]    cnt_q;
  logic                            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign rec_o   = mem_q[rptr_q];
  assign do_push = push_i && (cnt_q != sss_pkg::FifoCntW'(sss_pkg::FifoDepth));
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + sss_pkg::FifoPtrW'(1);
      if (do_pop)  rptr_q <= rptr_q + sss_pkg::FifoPtrW'(1);
      cnt_q <= cnt_q + sss_pkg::FifoCntW'(do_push) - sss_pkg::FifoCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= rec_i;
  end

endmodule

/* rtl/sss_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean and the variance.
// Depends on sss_pkg for the operand widths.
module sss_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sss_pkg::DivW-1:0]      dividend_i,
  input  logic [sss_pkg::DivisorW-1:0]  divisor_i,
  output logic                          done_o,
  output logic [sss_pkg::QuotW-1:0]     quot_o
);

  logic                          busy_q, done_q;
  logic [sss_pkg::DivCntW-1:0]   cnt_q;
  logic [sss_pkg::DivW-1:0]      dq_q;
  logic [sss_pkg::DivisorW-1:0]  div_q, rem_q;
  logic [sss_pkg::DivisorW:0]    rem_sh, rem_sub;
  logic                          ge;

  // The dividend shifts out of the top while quotient bits shift in at the bottom.
  assign rem_sh  = {rem_q, dq_q[sss_pkg::DivW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge      = rem_sh >= {1'b0, div_q};

  assign done_o = done_q;
  assign quot_o = dq_q[sss_pkg::QuotW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= sss_pkg::DivCntW'(sss_pkg::DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - sss_pkg::DivCntW'(1);
        if (cnt_q == sss_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[sss_pkg::DivisorW-1:0] : rem_sh[sss_pkg::DivisorW-1:0];
      dq_q  <= {dq_q[sss_pkg::DivW-2:0], ge};
    end
  end

endmodule

/* rtl/sss_back.sv */
// Back part: turns one set record into min, max, mean, standard deviation, count and overflow flag.
// Uses sss_div for both divisions and an in-place bit-pair square root; depends on sss_pkg.
module sss_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sss_pkg::set_rec_t                   rec_i,
  input  logic                                fifo_empty_i,
  output logic                                fifo_pop_o,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [sss_pkg::SampleW-1:0]  min_value_o,
  output logic signed [sss_pkg::SampleW-1:0]  max_value_o,
  output logic signed [sss_pkg::MeanW-1:0]    mean_q8_o,
  output logic [sss_pkg::SdW-1:0]             stddev_q8_o,
  output logic [sss_pkg::CountW-1:0]          sample_count_o,
  output logic                                overflow_o
);

  sss_pkg::back_state_e state_q, state_d;

  logic signed [sss_pkg::SampleW-1:0] min_q, max_q;
  logic                               neg_sum_q, ovf_q, var_neg_q;
  logic [sss_pkg::MagW-1:0]           mag_q, rec_mag;
  logic [sss_pkg::SqSumW-1:0]         sum_sq_q;
  logic [sss_pkg::CountW-1:0]         n_q;
  logic [40:0]                        p_q;
  logic [39:0]                        t_q;
  logic [63:0]                        sq_q, a_q, diff_q;
  logic [sss_pkg::DivisorW-1:0]       nn_q;
  logic [sss_pkg::MeanW-1:0]          mean_q, mean_sat;
  logic [sss_pkg::QuotW-1:0]          x_q, res_q, bit_q, trial;
  logic                               sq_ge;

  logic                               out_valid_q, load_out;
  logic                               div_start, div_done;
  logic [sss_pkg::DivW-1:0]           div_dividend;
  logic [sss_pkg::DivisorW-1:0]       div_divisor;
  logic [sss_pkg::QuotW-1:0]          div_quot;

  sss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign rec_mag = rec_i.sum[sss_pkg::SumW-1] ? sss_pkg::MagW'(-rec_i.sum)
                                              : sss_pkg::MagW'(rec_i.sum);

  always_comb begin
    if (neg_sum_q) begin
      mean_sat = (div_quot > sss_pkg::MeanNegLimit) ? sss_pkg::MeanNegSat
                                                    : sss_pkg::MeanW'(-div_quot);
    end else begin
      mean_sat = (div_quot > sss_pkg::MeanPosLimit) ? sss_pkg::MeanPosSat
                                                    : div_quot[sss_pkg::MeanW-1:0];
    end
  end

  assign trial = res_q + bit_q;
  assign sq_ge = x_q >= trial;

  always_comb begin
    state_d      = state_q;
    fifo_pop_o   = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    div_dividend = sss_pkg::DivW'({mag_q, 8'b0});
    div_divisor  = sss_pkg::DivisorW'(n_q);
    unique case (state_q)
      sss_pkg::BK_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          state_d    = sss_pkg::BK_MUL0;
        end
      end
      sss_pkg::BK_MUL0: state_d = sss_pkg::BK_MUL1;
      sss_pkg::BK_MUL1: state_d = sss_pkg::BK_SUM;
      sss_pkg::BK_SUM:  state_d = sss_pkg::BK_DIFF;
      sss_pkg::BK_DIFF: begin
        // An empty set reports zero mean and deviation without dividing.
        state_d = (n_q == '0) ? sss_pkg::BK_OUT : sss_pkg::BK_MEAN_START;
      end
      sss_pkg::BK_MEAN_START: begin
        div_start = 1'b1;
        state_d   = sss_pkg::BK_MEAN_WAIT;
      end
      sss_pkg::BK_MEAN_WAIT: begin
        if (div_done) begin
          state_d = var_neg_q ? sss_pkg::BK_OUT : sss_pkg::BK_VAR_START;
        end
      end
      sss_pkg::BK_VAR_START: begin
        div_start    = 1'b1;
        div_dividend = {diff_q, 16'b0};
        div_divisor  = nn_q;
        state_d      = sss_pkg::BK_VAR_WAIT;
      end
      sss_pkg::BK_VAR_WAIT: begin
        if (div_done) state_d = sss_pkg::BK_SQRT;
      end
      sss_pkg::BK_SQRT: begin
        if (bit_q[0]) state_d = sss_pkg::BK_OUT;
      end
      sss_pkg::BK_OUT: begin
        if (!out_valid_q || pop) begin
          load_out = 1'b1;
          state_d  = sss_pkg::BK_IDLE;
        end
      end
      default: state_d = sss_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sss_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      sss_pkg::BK_IDLE: begin
        if (!fifo_empty_i) begin
          min_q     <= rec_i.min_value;
          max_q     <= rec_i.max_value;
          neg_sum_q <= rec_i.sum[sss_pkg::SumW-1];
          mag_q     <= rec_mag;
          sum_sq_q  <= rec_i.sum_sq;
          n_q       <= rec_i.count;
          ovf_q     <= rec_i.overflow;
        end
      end
      sss_pkg::BK_MUL0: begin
        p_q  <= 41'(n_q) * 41'(sum_sq_q[23:0]);
        sq_q <= 64'(mag_q) * 64'(mag_q);
      end
      sss_pkg::BK_MUL1: begin
        t_q  <= 40'(n_q) * 40'(sum_sq_q[sss_pkg::SqSumW-1:24]);
        nn_q <= sss_pkg::DivisorW'(n_q) * sss_pkg::DivisorW'(n_q);
      end
      sss_pkg::BK_SUM: a_q <= 64'(p_q) + {t_q, 24'b0};
      sss_pkg::BK_DIFF: begin
        var_neg_q <= a_q < sq_q;
        diff_q    <= a_q - sq_q;
        if (n_q == '0) begin
          mean_q <= '0;
          res_q  <= '0;
        end
      end
      sss_pkg::BK_MEAN_WAIT: begin
        if (div_done) begin
          mean_q <= mean_sat;
          if (var_neg_q) res_q <= '0;
        end
      end
      sss_pkg::BK_VAR_WAIT: begin
        if (div_done) begin
          x_q   <= div_quot;
          res_q <= '0;
          bit_q <= sss_pkg::SqrtTopBit;
        end
      end
      sss_pkg::BK_SQRT: begin
        if (sq_ge) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
    if (load_out) begin
      min_value_o    <= min_q;
      max_value_o    <= max_q;
      mean_q8_o      <= mean_q;
      stddev_q8_o    <= res_q[sss_pkg::SdW-1:0];
      sample_count_o <= n_q;
      overflow_o     <= ovf_q;
    end
  end

  assign empty = ~out_valid_q;

endmodule

/* rtl/sample_set_statistics_unit.sv */
// Top level of the sample set statistics unit: front accumulator, set queue and back calculator.
// Depends on sss_pkg, sss_front, sss_fifo and sss_back.
//
//   Channel   Handshake               Fields
//   input     push / full             sample_i, last_i
//   result    empty / pop             min_value_o, max_value_o, mean_q8_o, stddev_q8_o,
//                                     sample_count_o, overflow_o
//
// Samples are taken one per cycle while full is low; a set's result follows its last sample
// after the two 80-step divisions and the 24-step square root in the back.
// The back handles one set at a time; up to four finished sets wait in the queue.
// full rises only when the queue has no room for another finished set.
// rst_ni is asynchronous and active low; it empties the queue and clears the accumulators.
module sample_set_statistics_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sss_pkg::SampleW-1:0]  sample_i,
  input  logic                                last_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [sss_pkg::SampleW-1:0]  min_value_o,
  output logic signed [sss_pkg::SampleW-1:0]  max_value_o,
  output logic signed [sss_pkg::MeanW-1:0]    mean_q8_o,
  output logic [sss_pkg::SdW-1:0]             stddev_q8_o,
  output logic [sss_pkg::CountW-1:0]          sample_count_o,
  output logic                                overflow_o
);

  sss_pkg::set_rec_t               rec_in, rec_head;
  logic                            rec_push, rec_pop, fifo_empty;
  logic [sss_pkg::FifoCntW-1:0]    fifo_cnt;

  sss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .fifo_cnt_i (fifo_cnt),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  sss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .pop_i   (rec_pop),
    .rec_o   (rec_head),
    .empty_o (fifo_empty),
    .cnt_o   (fifo_cnt)
  );

  sss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_i          (rec_head),
    .fifo_empty_i   (fifo_empty),
    .fifo_pop_o     (rec_pop),
    .pop            (pop),
    .empty          (empty),
    .min_value_o    (min_value_o),
    .max_value_o    (max_value_o),
    .mean_q8_o      (mean_q8_o),
    .stddev_q8_o    (stddev_q8_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o)
  );

  // A finished set must always find room in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> (fifo_cnt != sss_pkg::FifoCntW'(sss_pkg::FifoDepth)))
    else $error("set record pushed into a full queue");

  // Every reported set holds at least one sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (sample_count_o != '0))
    else $error("result with zero samples");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (min_value_o <= max_value_o))
    else $error("minimum above maximum");

  // A single sample has no spread.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (sample_count_o == sss_pkg::CountW'(1))) |-> (stddev_q8_o == '0))
    else $error("nonzero deviation for a one-sample set");

endmodule
